// File: sv/dwpid_pkg.sv
package dwpid_pkg;

    // Width of each wheel's saturating error accumulator.
    localparam int SUM_WIDTH = 16;

    localparam int NOTCH_W = 8;
    localparam int GAIN_W  = 16;
    localparam int DUTY_W  = 16;
    localparam int ERR_W   = NOTCH_W + 1;
    localparam int SPEED_W = 17;
    localparam int PROD_W  = ERR_W + GAIN_W + 1;
    localparam int PRODI_W = SUM_WIDTH + GAIN_W + 1;
    localparam int ACC_W   = PRODI_W + 3;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;

    localparam logic [SPEED_W-1:0] SPEED_ONE = SPEED_W'(65536);

    localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_I = 3'd3;
    localparam logic [IDX_W-1:0] REG_PERIOD = 3'd4;

    typedef struct packed {
        logic [NOTCH_W-1:0] left_notches;
        logic [NOTCH_W-1:0] right_notches;
        logic               hold;
    } sample_t;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic              updated;
    } result_t;

    typedef struct packed {
        logic [NOTCH_W-1:0] target_count;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_d;
        logic [GAIN_W-1:0]  gain_i;
        logic [DUTY_W-1:0]  pwm_period;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
    } lane_ctl_t;

endpackage

// File: sv/dual_wheel_pid_speed_control.sv
// Dual-wheel incremental PID speed controller.
// Sample channel: sample_valid/sample_stall carry one tick with both encoder
// counts and the hold flag. Result channel: result_valid/result_stall return
// one result per sample with both duties and the updated flag.
// Configuration: cfg_valid/cfg_ready with cfg_index 0..4 (target, three gains,
// PWM period); cfg_ready is always high and other indexes are dropped.
// An update runs in 4 clocked steps: error capture at the sample transfer,
// the three gain products in parallel per wheel, the speed add and clamp, and
// the duty multiply into the result register. One sample is in flight at a
// time: a new sample is stalled until the last one has left the duty step. A
// held sample skips the lane steps and goes straight to the duty step.
// The two wheels run in identical lanes, and the result register merges them.
// A finished result waits in the output register while the next sample is
// already accepted; if the receiver stalls, the next result waits in the
// duty step until the register frees up.
// Reset sets both speeds to full scale, clears errors and sums and loads the
// default register values.
module dual_wheel_pid_speed_control
    import dwpid_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  sample_t          sample,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_DUTY = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    cfg_t        cfg_reg;
    logic        hold_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    lane_ctl_t   ctl;
    logic        sample_xfer;
    logic        out_load;
    logic [DUTY_W-1:0] left_duty, right_duty;

    assign cfg_ready    = 1'b1;
    assign sample_stall = (state_reg != ST_IDLE);
    assign sample_xfer  = sample_valid && !sample_stall;
    assign out_load     = (state_reg == ST_DUTY) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        ctl.load = sample_xfer;
        ctl.mul  = (state_reg == ST_MUL);
        ctl.upd  = (state_reg == ST_UPD);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    state_next = sample.hold ? ST_DUTY : ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_DUTY;
            ST_DUTY:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            hold_reg      <= 1'b0;
            cfg_reg.target_count <= 8'd9;
            cfg_reg.gain_p       <= 16'd9175;
            cfg_reg.gain_d       <= 16'd4588;
            cfg_reg.gain_i       <= 16'd2294;
            cfg_reg.pwm_period   <= 16'd10000;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (sample_xfer)
            begin
                hold_reg <= sample.hold;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TARGET: cfg_reg.target_count <= cfg_data[NOTCH_W-1:0];
                    REG_GAIN_P: cfg_reg.gain_p       <= cfg_data;
                    REG_GAIN_D: cfg_reg.gain_d       <= cfg_data;
                    REG_GAIN_I: cfg_reg.gain_i       <= cfg_data;
                    REG_PERIOD: cfg_reg.pwm_period   <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    dwpid_lane u_left
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .cfg     (cfg_reg),
        .notches (sample.left_notches),
        .duty    (left_duty)
    );

    dwpid_lane u_right
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .cfg     (cfg_reg),
        .notches (sample.right_notches),
        .duty    (right_duty)
    );

    // A held sample reports zero duties and leaves both lanes' speed, last error and sum untouched.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.left_duty  <= hold_reg ? '0 : left_duty;
            out_reg.right_duty <= hold_reg ? '0 : right_duty;
            out_reg.updated    <= !hold_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: sv/dwpid_lane.sv
module dwpid_lane
    import dwpid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_ctl_t          ctl,
    input  cfg_t               cfg,
    input  logic [NOTCH_W-1:0] notches,
    output logic [DUTY_W-1:0]  duty
);

    logic [SPEED_W-1:0]          speed_reg, speed_next;
    logic signed [ERR_W-1:0]     last_err_reg;
    logic signed [SUM_WIDTH-1:0] sum_reg, sum_next;
    logic signed [ERR_W-1:0]     err_reg;
    logic signed [PROD_W-1:0]    prod_p_reg, prod_d_reg;
    logic signed [PRODI_W-1:0]   prod_i_reg;
    logic signed [ERR_W-1:0]     err_new;
    logic signed [ACC_W-1:0]     acc;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic [2*SPEED_W-2:0]        duty_prod;

    assign err_new = $signed({1'b0, cfg.target_count}) - $signed({1'b0, notches});

    always_comb
    begin
        acc = ACC_W'($signed({1'b0, speed_reg})) + ACC_W'(prod_p_reg)
            + ACC_W'(prod_d_reg) + ACC_W'(prod_i_reg);
        if (acc[ACC_W-1])
        begin
            speed_next = '0;
        end
        else if ((acc[ACC_W-2:SPEED_W] != '0) || (acc[SPEED_W-1] && (acc[SPEED_W-2:0] != '0)))
        begin
            speed_next = SPEED_ONE;
        end
        else
        begin
            speed_next = acc[SPEED_W-1:0];
        end
    end

    // The accumulator saturates instead of wrapping.
    always_comb
    begin
        sum_wide = (SUM_WIDTH+1)'(sum_reg) + (SUM_WIDTH+1)'(err_reg);
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
        begin
            sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                           : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
        else
        begin
            sum_next = sum_wide[SUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg    <= SPEED_ONE;
            last_err_reg <= '0;
            sum_reg      <= '0;
        end
        else if (ctl.upd)
        begin
            speed_reg    <= speed_next;
            last_err_reg <= err_reg;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            err_reg <= err_new;
        end
        if (ctl.mul)
        begin
            prod_p_reg <= err_reg * $signed({1'b0, cfg.gain_p});
            prod_d_reg <= last_err_reg * $signed({1'b0, cfg.gain_d});
            prod_i_reg <= sum_reg * $signed({1'b0, cfg.gain_i});
        end
    end

    // Speed is at most 1.0, so the product fits below bit 32.
    assign duty_prod = (2*SPEED_W-1)'(speed_reg) * (2*SPEED_W-1)'(cfg.pwm_period);
    assign duty      = duty_prod[DUTY_W+15:16];

endmodule

// File: test/tb_dual_wheel_pid_speed_control.sv
`timescale 1ns / 1ps

module tb_dual_wheel_pid_speed_control;
    import dwpid_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 250;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;
    typedef enum int {TICK_NEAR, TICK_RANDOM, TICK_STARVE, TICK_FLOOD} tick_style_t;

    logic             clk;
    logic             rst_n;
    logic             sample_valid;
    logic             sample_stall;
    sample_t          sample;
    logic             result_valid;
    logic             result_stall;
    result_t          result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    dual_wheel_pid_speed_control dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Controller image: registers and per-wheel state, index 0 left, 1 right.
    logic [NOTCH_W-1:0]          target_reg;
    logic [GAIN_W-1:0]           kp_reg;
    logic [GAIN_W-1:0]           kd_reg;
    logic [GAIN_W-1:0]           ki_reg;
    logic [DUTY_W-1:0]           period_reg;
    logic [SPEED_W-1:0]          wheel_speed [2];
    logic signed [ERR_W-1:0]     wheel_last_err [2];
    logic signed [SUM_WIDTH-1:0] wheel_sum [2];

    sample_t tick_queue [$];
    result_t expected_duties [$];
    int      queued_count;
    int      checked_count;
    int      accepted_ticks;
    int      mismatches;
    int      quiet_cycles;

    logic         sample_taken;
    int           burst_left;
    int           gap_left;
    stall_style_t stall_style;
    int           style_left;
    int           long_hold_left;
    int           next_long_at;

    always #2 clk = ~clk;

    function automatic logic [DUTY_W-1:0] step_wheel(int k, logic [NOTCH_W-1:0] notches);
        longint err;
        longint inc;
        longint sp;
        longint ns;
        longint sum_hi;
        longint sum_lo;
        longint duty;
        sum_hi = (longint'(1) << (SUM_WIDTH - 1)) - 1;
        sum_lo = -sum_hi - 1;
        err = longint'(target_reg) - longint'(notches);
        inc = err * longint'(kp_reg)
            + longint'(wheel_last_err[k]) * longint'(kd_reg)
            + longint'(wheel_sum[k]) * longint'(ki_reg);
        sp = longint'(wheel_speed[k]) + inc;
        if (sp < 0)
            sp = 0;
        if (sp > longint'(SPEED_ONE))
            sp = longint'(SPEED_ONE);
        wheel_speed[k] = SPEED_W'(sp);
        wheel_last_err[k] = ERR_W'(err);
        ns = longint'(wheel_sum[k]) + err;
        if (ns > sum_hi)
            ns = sum_hi;
        if (ns < sum_lo)
            ns = sum_lo;
        wheel_sum[k] = SUM_WIDTH'(ns);
        duty = (longint'(wheel_speed[k]) * longint'(period_reg)) >>> 16;
        return DUTY_W'(duty);
    endfunction

    function automatic result_t predict_duties(sample_t s);
        result_t r;
        r = '0;
        // A held tick parks both motors and leaves the loop state alone.
        if (!s.hold) begin
            r.left_duty  = step_wheel(0, s.left_notches);
            r.right_duty = step_wheel(1, s.right_notches);
            r.updated    = 1'b1;
        end
        return r;
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Driver: bursts of transfers separated by random gaps.
    always @(posedge clk)
        sample_taken <= sample_valid && !sample_stall;

    always @(negedge clk) begin
        if (!sample_valid || sample_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                sample_valid <= 1'b0;
            end
            else if (tick_queue.size() != 0) begin
                sample       <= tick_queue.pop_front();
                sample_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // Receiver back-pressure, plus two long hold-offs that fill the pipeline.
    always @(negedge clk) begin
        if (!rst_n)
            result_stall <= 1'b0;
        else begin
            if (style_left == 0) begin
                stall_style = stall_style_t'($urandom_range(0, 3));
                style_left  = $urandom_range(20, 120);
            end
            else
                style_left--;
            if (long_hold_left == 0 && next_long_at != 0 && accepted_ticks >= next_long_at) begin
                long_hold_left = LONG_HOLD;
                next_long_at   = (next_long_at == 400) ? 900 : 0;
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                result_stall <= 1'b1;
            end
            else begin
                case (stall_style)
                    STALL_NONE:  result_stall <= 1'b0;
                    STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
                    default:     result_stall <= ~result_stall;
                endcase
            end
        end
    end

    // Monitor: predicts on each sample transfer, checks each result transfer.
    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                checked_count++;
                if (expected_duties.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    mismatches++;
                end
                else begin
                    want = expected_duties.pop_front();
                    compare_field("left_duty", want.left_duty, result.left_duty);
                    compare_field("right_duty", want.right_duty, result.right_duty);
                    compare_field("updated", want.updated, result.updated);
                end
            end
            if (sample_valid && !sample_stall) begin
                expected_duties.push_back(predict_duties(sample));
                accepted_ticks++;
            end
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_TARGET: target_reg = data[NOTCH_W-1:0];
            REG_GAIN_P: kp_reg     = data;
            REG_GAIN_D: kd_reg     = data;
            REG_GAIN_I: ki_reg     = data;
            REG_PERIOD: period_reg = data;
            default: ;
        endcase
    endtask

    task automatic program_regs(logic [NOTCH_W-1:0] target, logic [GAIN_W-1:0] kp,
                                logic [GAIN_W-1:0] kd, logic [GAIN_W-1:0] ki,
                                logic [DUTY_W-1:0] period);
        logic [IDX_W-1:0] bogus;
        bogus = REG_PERIOD + IDX_W'($urandom_range(1, 3));
        write_reg(REG_TARGET, {8'($urandom), target});
        write_reg(bogus, 16'($urandom));
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_PERIOD, period);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_tick(logic [NOTCH_W-1:0] left, logic [NOTCH_W-1:0] right, logic hold);
        sample_t s;
        s.left_notches  = left;
        s.right_notches = right;
        s.hold          = hold;
        tick_queue.push_back(s);
        queued_count++;
    endtask

    function automatic logic [NOTCH_W-1:0] pick_notches(tick_style_t style);
        int v;
        case (style)
            TICK_NEAR: begin
                v = int'(target_reg) + int'($urandom_range(0, 12)) - 6;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
            end
            TICK_STARVE: v = $urandom_range(0, 3);
            TICK_FLOOD:  v = $urandom_range(252, 255);
            default:     v = $urandom_range(0, 255);
        endcase
        return NOTCH_W'(v);
    endfunction

    task automatic queue_run(int count, tick_style_t style);
        tick_style_t s;
        for (int n = 0; n < count; n++) begin
            // Mostly the phase's own pattern, with some fully random noise.
            s = ($urandom_range(0, 9) == 0) ? TICK_RANDOM : style;
            queue_tick(pick_notches(s), pick_notches(s), $urandom_range(0, 9) == 0);
        end
    endtask

    // Returns once every queued tick has produced its result and the
    // pipeline has had time to settle.
    task automatic drain;
        while (checked_count != queued_count)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        return ($urandom_range(0, 1) != 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 4095));
    endfunction

    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        sample         = '0;
        result_stall   = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        sample_taken   = 1'b0;
        burst_left     = 0;
        gap_left       = 0;
        stall_style    = STALL_NONE;
        style_left     = 0;
        long_hold_left = 0;
        next_long_at   = 400;
        queued_count   = 0;
        checked_count  = 0;
        accepted_ticks = 0;
        mismatches     = 0;
        quiet_cycles   = 0;
        target_reg     = 8'd9;
        kp_reg         = 16'd9175;
        kd_reg         = 16'd4588;
        ki_reg         = 16'd2294;
        period_reg     = 16'd10000;
        for (int k = 0; k < 2; k++) begin
            wheel_speed[k]    = SPEED_ONE;
            wheel_last_err[k] = '0;
            wheel_sum[k]      = '0;
        end

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed ticks on the reset register values.
        queue_tick(8'd0, 8'd0, 1'b0);
        queue_tick(8'd255, 8'd255, 1'b0);
        queue_tick(8'd9, 8'd9, 1'b0);
        queue_tick(8'd0, 8'd255, 1'b0);
        queue_tick(8'd255, 8'd0, 1'b0);
        queue_tick(8'd9, 8'd9, 1'b1);
        queue_tick(8'd255, 8'd255, 1'b1);
        queue_tick(8'd0, 8'd0, 1'b1);
        queue_tick(8'd8, 8'd10, 1'b0);
        queue_tick(8'd10, 8'd8, 1'b0);
        queue_tick(8'hAA, 8'h55, 1'b0);
        queue_tick(8'h55, 8'hAA, 1'b0);
        queue_tick(8'd0, 8'd0, 1'b0);
        queue_tick(8'd0, 8'd0, 1'b0);
        queue_tick(8'd255, 8'd255, 1'b0);
        queue_tick(8'd255, 8'd255, 1'b0);
        queue_tick(8'd9, 8'd9, 1'b0);
        queue_tick(8'h5A, 8'hA5, 1'b1);
        drain();

        // Full gains with starved wheels: speed pins high and the error
        // sum runs into its positive limit.
        program_regs(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_run(150, TICK_STARVE);
        drain();

        // Overspeed with a zero target drives the sum to its negative limit.
        program_regs(8'd0, 16'hFFFF, 16'd0, 16'd0, 16'd1);
        queue_run(300, TICK_FLOOD);
        drain();

        // No gain and a zero PWM period.
        program_regs(8'd128, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_run(80, TICK_RANDOM);
        drain();

        program_regs(8'd9, 16'd9175, 16'd4588, 16'd2294, 16'd10000);
        queue_run(90, TICK_NEAR);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            program_regs(NOTCH_W'($urandom), pick_gain(), pick_gain(), pick_gain(),
                         DUTY_W'($urandom_range(1, 65535)));
            queue_run(95, (phase % 3 == 2) ? TICK_RANDOM : TICK_NEAR);
            drain();
        end

        if (expected_duties.size() != 0) begin
            $error("%0d expected results never arrived", expected_duties.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
